// ===== rtl/csht_pkg.sv =====
// shared constants, types and codes of the callsite count hash table
package csht_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int HASH_SHIFT  = 4;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);

    localparam int ADDR_W  = 64;
    localparam int PHASE_W = 4;
    localparam int OWNER_W = 16;
    localparam int COUNT_W = 64;
    localparam int INDEX_W = 10;
    localparam int STAT_W  = 3;

    localparam logic [SLOT_BITS-1:0] SLOT_MAX = SLOT_BITS'(TABLE_SLOTS - 1);

    localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic               used;
        logic [ADDR_W-1:0]  callsite;
        logic [ADDR_W-1:0]  parent;
        logic [PHASE_W-1:0] phase;
        logic [OWNER_W-1:0] owner;
        logic [COUNT_W-1:0] events;
        logic [COUNT_W-1:0] violations;
        logic [COUNT_W-1:0] bytes;
    } csht_entry_t;

    localparam int ENTRY_W = $bits(csht_entry_t);

    typedef struct packed {
        logic              load_req;
        logic              sweep_start;
        logic              sweep_step;
        logic              probe_start;
        logic              probe_next;
        logic              rd_en;
        logic              commit;
        logic              report;
        logic [STAT_W-1:0] report_code;
    } csht_cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_clear;
        logic in_zero;
        logic sweep_last;
        logic slot_free;
        logic slot_match;
        logic probe_last;
    } csht_stat_t;

endpackage

// ===== rtl/csht_ram.sv =====
// generic simple dual port ram with registered read
module csht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csht_datapath.sv =====
// request registers, slot table, probe address, update adders and result register
module csht_datapath
    import csht_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  csht_cmd_t          cmd,
    output csht_stat_t         stat,
    input  logic               s_cmd,
    input  logic [ADDR_W-1:0]  s_callsite_addr,
    input  logic [ADDR_W-1:0]  s_parent_addr,
    input  logic [PHASE_W-1:0] s_phase,
    input  logic [OWNER_W-1:0] s_owner,
    input  logic               s_violation,
    input  logic [COUNT_W-1:0] s_byte_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [INDEX_W-1:0] m_slot_index,
    output logic [COUNT_W-1:0] m_event_count,
    output logic [COUNT_W-1:0] m_violation_total,
    output logic [COUNT_W-1:0] m_byte_total
);

    logic [ADDR_W-1:0]    callsite_reg;
    logic [ADDR_W-1:0]    parent_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic                 viol_reg;
    logic [COUNT_W-1:0]   bytes_reg;

    logic [SLOT_BITS-1:0] addr_reg;
    logic [SLOT_BITS-1:0] addr_next;
    logic [SLOT_BITS-1:0] addr_inc;
    logic [SLOT_BITS-1:0] probe_cnt_reg;
    logic [SLOT_BITS-1:0] probe_cnt_next;

    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    csht_entry_t          rd_entry;
    csht_entry_t          wr_entry;

    logic                 m_valid_reg;
    logic [STAT_W-1:0]    m_status_reg;
    logic [INDEX_W-1:0]   m_slot_index_reg;
    logic [COUNT_W-1:0]   m_event_count_reg;
    logic [COUNT_W-1:0]   m_violation_total_reg;
    logic [COUNT_W-1:0]   m_byte_total_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            callsite_reg <= s_callsite_addr;
            parent_reg   <= s_parent_addr;
            phase_reg    <= s_phase;
            owner_reg    <= s_owner;
            viol_reg     <= s_violation;
            bytes_reg    <= s_byte_count;
        end
    end

    // probe and sweep address
    assign addr_inc = (addr_reg == SLOT_MAX) ? '0 : addr_reg + 1'b1;

    always_comb begin
        addr_next      = addr_reg;
        probe_cnt_next = probe_cnt_reg;
        if (cmd.sweep_start) begin
            addr_next = '0;
        end else if (cmd.probe_start) begin
            addr_next      = s_callsite_addr[HASH_SHIFT +: SLOT_BITS];
            probe_cnt_next = '0;
        end else if (cmd.sweep_step) begin
            addr_next = addr_inc;
        end else if (cmd.probe_next) begin
            addr_next      = addr_inc;
            probe_cnt_next = probe_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            probe_cnt_reg <= '0;
        end else begin
            addr_reg      <= addr_next;
            probe_cnt_reg <= probe_cnt_next;
        end
    end

    // table storage
    assign rd_entry = csht_entry_t'(ram_rdata);

    always_comb begin
        wr_entry.used     = 1'b1;
        wr_entry.callsite = callsite_reg;
        wr_entry.parent   = parent_reg;
        wr_entry.phase    = phase_reg;
        wr_entry.owner    = owner_reg;
        if (!rd_entry.used) begin
            wr_entry.events     = COUNT_W'(1);
            wr_entry.violations = COUNT_W'(viol_reg);
            wr_entry.bytes      = bytes_reg;
        end else begin
            wr_entry.events     = rd_entry.events + COUNT_W'(1);
            wr_entry.violations = rd_entry.violations + COUNT_W'(viol_reg);
            wr_entry.bytes      = rd_entry.bytes + bytes_reg;
        end
    end

    assign ram_we    = cmd.sweep_step | cmd.commit;
    assign ram_wdata = cmd.sweep_step ? '0 : ENTRY_W'(wr_entry);

    csht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit || cmd.report) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg          <= rd_entry.used ? ST_UPDATED : ST_NEW;
            m_slot_index_reg      <= INDEX_W'(addr_reg);
            m_event_count_reg     <= wr_entry.events;
            m_violation_total_reg <= wr_entry.violations;
            m_byte_total_reg      <= wr_entry.bytes;
        end else if (cmd.report) begin
            m_status_reg          <= cmd.report_code;
            m_slot_index_reg      <= '0;
            m_event_count_reg     <= '0;
            m_violation_total_reg <= '0;
            m_byte_total_reg      <= '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_slot_index      = m_slot_index_reg;
    assign m_event_count     = m_event_count_reg;
    assign m_violation_total = m_violation_total_reg;
    assign m_byte_total      = m_byte_total_reg;

    // status to controller
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.in_clear   = s_cmd;
    assign stat.in_zero    = (s_callsite_addr == '0);
    assign stat.sweep_last = (addr_reg == SLOT_MAX);
    assign stat.slot_free  = !rd_entry.used;
    assign stat.slot_match = rd_entry.used && (rd_entry.callsite == callsite_reg)
                             && (rd_entry.parent == parent_reg)
                             && (rd_entry.phase == phase_reg);
    assign stat.probe_last = (probe_cnt_reg == SLOT_MAX);

endmodule

// ===== rtl/csht_ctrl.sv =====
// controller state machine: reset sweep, clear sweep, probe sequence and result hand-off
module csht_ctrl
    import csht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  csht_stat_t stat,
    output csht_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CLEAR  = 7'b0000100,
        S_READ   = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_REPORT = 7'b1000000
    } csht_state_t;

    csht_state_t       state_reg;
    csht_state_t       state_next;
    logic [STAT_W-1:0] code_reg;
    logic [STAT_W-1:0] code_next;

    always_comb begin
        state_next      = state_reg;
        code_next       = code_reg;
        cmd             = '0;
        cmd.report_code = code_reg;
        s_ready         = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    if (stat.in_clear) begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_CLEAR;
                    end else if (stat.in_zero) begin
                        code_next  = ST_IGNORED;
                        state_next = S_REPORT;
                    end else begin
                        cmd.probe_start = 1'b1;
                        state_next      = S_READ;
                    end
                end
            end
            S_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    code_next  = ST_CLEARED;
                    state_next = S_REPORT;
                end
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (stat.slot_free || stat.slot_match) begin
                    state_next = S_UPDATE;
                end else if (stat.probe_last) begin
                    code_next  = ST_FULL;
                    state_next = S_REPORT;
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_UPDATE: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPORT: begin
                if (stat.out_free) begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            code_reg  <= ST_IGNORED;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ===== rtl/callsite_count_hash_table.sv =====
// callsite count hash table: top level joining controller and datapath
//
// Input channel s_*: one request per handshake. s_cmd = 1 clears the whole table,
// s_cmd = 0 records one event keyed by callsite, parent and phase. A zero callsite
// is ignored. Result channel m_*: exactly one result per request, in order, with a
// status code, the slot touched and the entry counters after the update.
// Sequence: an accepted record reads its home slot, compares it and then commits
// the result; each further linear probe adds one table read and one compare. A
// clear sweeps the slot table one slot a cycle through its single write port.
// Throughput: one request at a time; s_ready is high only between requests.
// After reset the same sweep empties the table and s_ready stays low until it
// ends. A result waits in the output register while m_ready is low; a new
// request is still taken, and its result is held back until the register
// frees up.
module callsite_count_hash_table
    import csht_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [ADDR_W-1:0]  s_callsite_addr,
    input  logic [ADDR_W-1:0]  s_parent_addr,
    input  logic [PHASE_W-1:0] s_phase,
    input  logic [OWNER_W-1:0] s_owner,
    input  logic               s_violation,
    input  logic [COUNT_W-1:0] s_byte_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [INDEX_W-1:0] m_slot_index,
    output logic [COUNT_W-1:0] m_event_count,
    output logic [COUNT_W-1:0] m_violation_total,
    output logic [COUNT_W-1:0] m_byte_total
);

    csht_cmd_t  cmd;
    csht_stat_t stat;

    csht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    csht_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_cmd             (s_cmd),
        .s_callsite_addr   (s_callsite_addr),
        .s_parent_addr     (s_parent_addr),
        .s_phase           (s_phase),
        .s_owner           (s_owner),
        .s_violation       (s_violation),
        .s_byte_count      (s_byte_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_slot_index      (m_slot_index),
        .m_event_count     (m_event_count),
        .m_violation_total (m_violation_total),
        .m_byte_total      (m_byte_total)
    );

endmodule
